>>> hdl/crt_pkg.sv
package crt_pkg;
   localparam int MAX_PAIRS_DEF    = 8;
   localparam int MODULUS_BITS_DEF = 8;
   localparam int PROD_W           = 64;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_COPRIME  = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   // one restoring division request/answer between sequencer and divider
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [7:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
      logic [7:0]        remainder;
   } div_rsp_type;
endpackage

>>> hdl/crt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module crt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  crt_pkg::div_req_type req,
   output crt_pkg::div_rsp_type rsp
);
   import crt_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [8:0]        rem_ff, rem_in;
   logic [7:0]        dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [8:0]        trial;
   logic [8:0]        diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[7:0], quo_ff[PROD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[8]) begin
            rem_in = diff;
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[7:0];
endmodule

>>> hdl/crt_combine.sv
// channel | direction | fields
// req     | in        | req_residue[7:0] req_modulus[7:0] req_last
// rsp     | out       | rsp_solution[63:0] rsp_product[63:0] rsp_error[1:0]
//
// a beat is stored while the store has room; the 8x64 product multiply is
// done in the same cycle
// a last beat starts the combine on the one shared serial divider; per pair
// the steps are fetch and check, cofactor, cofactor mod m, euclid steps (one
// division each, then a final check), residue mod m, multiply-mod and
// accumulate; the result register then loads in S_OUT once the previous
// result has left the output register
// reset is synchronous and clears the pair count, running product, overflow, output valid and the fsm
// req_stall is high from the last beat until its result is in the output
// register; a result beat waiting on rsp_stall does not block new beats
module crt_combine #(
   parameter int MAX_PAIRS    = crt_pkg::MAX_PAIRS_DEF,
   parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_residue,
   input  logic [7:0]              req_modulus,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [crt_pkg::PROD_W-1:0] rsp_solution,
   output logic [crt_pkg::PROD_W-1:0] rsp_product,
   output logic [1:0]              rsp_error
);
   import crt_pkg::*;

   localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CNT_W = $clog2(MAX_PAIRS + 1);
   localparam logic [7:0] FMASK = 8'((1 << MODULUS_BITS) - 1);

   typedef enum logic [12:0] {
      S_LOAD   = 13'b0000000000001,
      S_FETCH  = 13'b0000000000010,
      S_PAIR   = 13'b0000000000100,
      S_COF    = 13'b0000000001000,
      S_CMOD   = 13'b0000000010000,
      S_EUC    = 13'b0000000100000,
      S_EUCW   = 13'b0000001000000,
      S_RMOD   = 13'b0000010000000,
      S_AMUL   = 13'b0000100000000,
      S_AMOD   = 13'b0001000000000,
      S_TERM   = 13'b0010000000000,
      S_ACC    = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        res_mem [MAX_PAIRS];
   logic [7:0]        mod_mem [MAX_PAIRS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        m_ff, r_ff;
   logic [PROD_W-1:0] cof_ff, cof_in;
   logic [PROD_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0] term_ff, term_in;
   logic [PROD_W-1:0] gap_ff, gap_in;
   logic [8:0]        ea_ff, ea_in, eb_ff, eb_in;
   logic signed [9:0] es_ff, es_in, esn_ff, esn_in;
   logic [7:0]        inv_ff, inv_in;
   logic [15:0]       pa_ff, pa_in;
   logic [1:0]        err_ff, err_in;
   logic              vld_ff, vld_in;
   logic [PROD_W-1:0] sol_ff, sol_in, oprod_ff, oprod_in;
   logic [1:0]        oerr_ff, oerr_in;
   div_req_type       dreq;
   div_rsp_type       drsp;
   logic [7:0]        fres, fmod;
   logic              take;
   logic [IDX_W-1:0]  wr_idx;
   logic signed [9:0] s_adj;

   crt_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign fres      = req_residue & FMASK;
   assign fmod      = req_modulus & FMASK;
   assign req_stall = (state_ff != S_LOAD);
   assign take      = req_valid && !req_stall;
   assign wr_idx    = count_ff[IDX_W-1:0];

   // stored pair is read through a register, in the cycle after idx_ff settles
   always_ff @(posedge clock) begin
      if (take && count_ff < CNT_W'(MAX_PAIRS)) begin
         res_mem[wr_idx] <= fres;
         mod_mem[wr_idx] <= fmod;
      end
      m_ff <= mod_mem[idx_ff];
      r_ff <= res_mem[idx_ff];
   end

   always_comb begin
      s_adj = es_ff;
      if (es_ff < 0) s_adj = es_ff + $signed({2'b00, m_ff});
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      prod_in  = prod_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      cof_in   = cof_ff;
      x_in     = x_ff;
      term_in  = term_ff;
      gap_in   = gap_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      es_in    = es_ff;
      esn_in   = esn_ff;
      inv_in   = inv_ff;
      pa_in    = pa_ff;
      err_in   = err_ff;
      vld_in   = vld_ff && rsp_stall;
      sol_in   = sol_ff;
      oprod_in = oprod_ff;
      oerr_in  = oerr_ff;
      dreq     = '0;
      case (state_ff)
         S_LOAD: begin
            if (take) begin
               if (count_ff < CNT_W'(MAX_PAIRS)) begin
                  count_in = count_ff + 1'b1;
                  prod_in  = prod_ff * {56'd0, fmod};
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  idx_in   = '0;
                  x_in     = '0;
                  err_in   = ERR_OK;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_PAIR;
         end
         S_PAIR: begin
            if (ovf_ff) begin
               err_in   = ERR_OVERFLOW;
               state_in = S_OUT;
            end else if ({1'b0, idx_ff} >= (IDX_W+1)'(count_ff)) begin
               state_in = S_OUT;
            end else if (m_ff == 8'd0 || prod_ff == '0) begin
               err_in   = ERR_COPRIME;
               state_in = S_OUT;
            end else begin
               dreq.start    = 1'b1;
               dreq.dividend = prod_ff;
               dreq.divisor  = m_ff;
               state_in      = S_COF;
            end
         end
         S_COF: begin
            if (drsp.done) begin
               cof_in        = drsp.quotient;
               dreq.start    = 1'b1;
               dreq.dividend = drsp.quotient;
               dreq.divisor  = m_ff;
               state_in      = S_CMOD;
            end
         end
         S_CMOD: begin
            if (drsp.done) begin
               ea_in    = {1'b0, drsp.remainder};
               eb_in    = {1'b0, m_ff};
               es_in    = 10'sd1;
               esn_in   = 10'sd0;
               state_in = S_EUC;
            end
         end
         S_EUC: begin
            if (eb_ff == '0) begin
               if (ea_ff != 9'd1) begin
                  err_in   = ERR_COPRIME;
                  state_in = S_OUT;
               end else begin
                  // s lies within (-m, m)
                  inv_in        = s_adj[7:0];
                  dreq.start    = 1'b1;
                  dreq.dividend = {56'd0, r_ff};
                  dreq.divisor  = m_ff;
                  state_in      = S_RMOD;
               end
            end else begin
               dreq.start    = 1'b1;
               dreq.dividend = {56'd0, ea_ff[7:0]};
               dreq.divisor  = eb_ff[7:0];
               state_in      = S_EUCW;
            end
         end
         S_EUCW: begin
            if (drsp.done) begin
               ea_in    = eb_ff;
               eb_in    = {1'b0, drsp.remainder};
               es_in    = esn_ff;
               esn_in   = es_ff - $signed({2'b00, drsp.quotient[7:0]}) * esn_ff;
               state_in = S_EUC;
            end
         end
         S_RMOD: begin
            if (drsp.done) begin
               pa_in    = drsp.remainder * inv_ff;
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            dreq.start    = 1'b1;
            dreq.dividend = {48'd0, pa_ff};
            dreq.divisor  = m_ff;
            state_in      = S_AMOD;
         end
         S_AMOD: begin
            if (drsp.done) begin
               term_in  = cof_ff * {56'd0, drsp.remainder};
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            gap_in   = prod_ff - term_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (x_ff >= gap_ff) x_in = x_ff - gap_ff;
            else x_in = x_ff + term_ff;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(MAX_PAIRS - 1)) state_in = S_OUT;
            else state_in = S_FETCH;
         end
         S_OUT: begin
            if (!vld_ff) begin
               vld_in   = 1'b1;
               sol_in   = (err_ff != ERR_OK) ? '0 : x_ff;
               oprod_in = prod_ff;
               oerr_in  = err_ff;
               count_in = '0;
               prod_in  = PROD_W'(1);
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      cof_ff   <= cof_in;
      x_ff     <= x_in;
      term_ff  <= term_in;
      gap_ff   <= gap_in;
      ea_ff    <= ea_in;
      eb_ff    <= eb_in;
      es_ff    <= es_in;
      esn_ff   <= esn_in;
      inv_ff   <= inv_in;
      pa_ff    <= pa_in;
      err_ff   <= err_in;
      idx_ff   <= idx_in;
      sol_ff   <= sol_in;
      oprod_ff <= oprod_in;
      oerr_ff  <= oerr_in;
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         prod_ff  <= PROD_W'(1);
         ovf_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         prod_ff  <= prod_in;
         ovf_ff   <= ovf_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_solution = sol_ff;
   assign rsp_product  = oprod_ff;
   assign rsp_error    = oerr_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> req_stall) else $error("input taken while combining");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAIRS)) else $error("pair count beyond store");
   a_err_sol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_OK |-> rsp_solution == '0)
      else $error("error result with nonzero solution");
   a_sol_below: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ERR_OK && rsp_product != '0 |->
      rsp_solution < rsp_product) else $error("solution not reduced");
endmodule
